// ===== rtl/pointer_screen_wrap_core_macros.svh =====
// Assertion macros for the pointer screen wrap core.
// Define NO_ASSERTIONS to compile them away; uses i_clk and i_rst_n of the includer.
`ifndef POINTER_SCREEN_WRAP_CORE_MACROS_SVH
`define POINTER_SCREEN_WRAP_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PSW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pointer_screen_wrap_core: same-cycle check failed");
`define PSW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pointer_screen_wrap_core: next-cycle check failed");
`else
`define PSW_ASSERT_IMP(lbl, ante, cons)
`define PSW_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/psw_pkg.sv =====
// Shared types and constants for the pointer screen wrap core.
// No dependencies; imported by the divider and the top level.
`default_nettype none
package psw_pkg;

    localparam int MAX_SCREENS = 8;
    localparam int IDX_W       = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;
    localparam int CNT_W       = $clog2(MAX_SCREENS + 1);

    localparam int COORD_W     = 16;
    localparam int DIM_W       = 15;
    localparam int TGT_W       = 17;
    localparam int SCNT_W      = 4;
    localparam int PROD_W      = 2 * DIM_W;
    localparam int DIV_STEPS   = DIM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 15;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_COUNT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOTAL_WIDTH  = 1'd1;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } t_screen;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [DIM_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIM_W-1:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== rtl/pointer_screen_wrap_core.sv =====
// Pointer screen wrap core: screen table, edge search and warp target; one item at a time.
// A sample reads and checks table entries in turn up to the hit; a top or bottom row hit adds
// a warp (next-entry read, multiply, divider start, serial divide) before the output register.
// No new item is taken until the result is loaded there. Reset is synchronous, active low:
// clears the sequencer and output valid, sets the config registers to one screen and width
// 1920. The screen table is not cleared; entries must be loaded before samples read them.
`default_nettype none
`include "pointer_screen_wrap_core_macros.svh"
module pointer_screen_wrap_core
    import psw_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic                      i_cmd,
    input  wire logic [2:0]                i_screen_index,
    input  wire logic signed [COORD_W-1:0] i_origin_x,
    input  wire logic signed [COORD_W-1:0] i_origin_y,
    input  wire logic [DIM_W-1:0]          i_screen_width,
    input  wire logic [DIM_W-1:0]          i_screen_height,
    input  wire logic signed [COORD_W-1:0] i_pointer_x,
    input  wire logic signed [COORD_W-1:0] i_pointer_y,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic                           o_found,
    output logic                           o_moved,
    output logic signed [TGT_W-1:0]        o_warp_x,
    output logic signed [TGT_W-1:0]        o_warp_y
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_NREAD  = 3'd3;
    localparam logic [2:0] S_NLOAD  = 3'd4;
    localparam logic [2:0] S_DSTART = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0]                r_state;
    logic [SCNT_W-1:0]         r_screen_count;
    logic [DIM_W-1:0]          r_total_width;
    logic [IDX_W-1:0]          r_idx;
    logic [CNT_W-1:0]          r_n;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic [DIM_W-1:0]          r_off;
    logic [DIM_W-1:0]          r_div_w;
    logic                      r_top;
    t_screen                   r_nxt;
    logic [PROD_W-1:0]         r_prod;
    logic                      r_found;
    logic                      r_moved;
    logic signed [TGT_W-1:0]   r_tx;
    logic signed [TGT_W-1:0]   r_ty;
    logic                      r_ovalid;

    logic                      w_in_acc;
    logic                      w_out_load;
    logic                      w_we;
    t_screen                   w_wentry;
    logic [$bits(t_screen)-1:0] w_rdata;
    t_screen                   s_rd;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;

    logic signed [17:0]        w_px;
    logic signed [17:0]        w_py;
    logic signed [17:0]        w_ox;
    logic signed [17:0]        w_oy;
    logic signed [17:0]        w_right;
    logic signed [17:0]        w_bottom;
    logic signed [17:0]        w_tw;
    logic                      w_hit;
    logic                      w_top;
    logic                      w_bot;
    logic                      w_left_edge;
    logic                      w_right_edge;
    logic [CNT_W-1:0]          w_idx_inc;
    logic [4:0]                w_cnt_ext;
    logic [CNT_W-1:0]          w_n_sat;
    logic signed [TGT_W-1:0]   w_tx_warp;
    logic signed [TGT_W-1:0]   w_ty_warp;
    logic signed [TGT_W-1:0]   w_tx_base;
    logic signed [TGT_W-1:0]   w_tx_fin;
    logic                      w_moved_fin;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_load  = (r_state == S_OUT) && (!r_ovalid || i_out_ready);

    // Loads to an index beyond the table are dropped.
    assign w_we = w_in_acc && (i_cmd == CMD_LOAD) &&
                  (5'(i_screen_index) < 5'(MAX_SCREENS));
    assign w_wentry.ox     = i_origin_x;
    assign w_wentry.oy     = i_origin_y;
    assign w_wentry.width  = i_screen_width;
    assign w_wentry.height = i_screen_height;

    psw_ram #(
        .WIDTH ($bits(t_screen)),
        .DEPTH (MAX_SCREENS),
        .ADDR_W(IDX_W)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(IDX_W'(i_screen_index)),
        .i_wdata(w_wentry),
        .i_raddr(r_idx),
        .o_rdata(w_rdata)
    );

    assign s_rd = t_screen'(w_rdata);

    assign div_req.start    = (r_state == S_DSTART);
    assign div_req.dividend = r_prod;
    assign div_req.divisor  = r_div_w;

    psw_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    always_comb begin
        w_px     = 18'(r_px);
        w_py     = 18'(r_py);
        w_ox     = 18'($signed(s_rd.ox));
        w_oy     = 18'($signed(s_rd.oy));
        w_right  = w_ox + $signed(18'(s_rd.width));
        w_bottom = w_oy + $signed(18'(s_rd.height));
        w_hit    = (w_px >= w_ox) && (w_px < w_right) && (w_py >= w_oy) && (w_py < w_bottom);
        w_top    = (w_py <= w_oy);
        w_bot    = (w_py >= (w_bottom - 18'sd1));

        w_idx_inc = CNT_W'(r_idx) + CNT_W'(1);
        w_cnt_ext = 5'(r_screen_count);
        w_n_sat   = (w_cnt_ext > 5'(MAX_SCREENS)) ? CNT_W'(MAX_SCREENS) : CNT_W'(w_cnt_ext);

        w_tx_warp = 17'($signed(r_nxt.ox)) + $signed(17'(div_rsp.quotient));
        w_ty_warp = r_top ? (17'($signed(r_nxt.oy)) + $signed(17'(r_nxt.height)) - 17'sd2)
                          : (17'($signed(r_nxt.oy)) + 17'sd1);
    end

    // Global horizontal wrap, applied to whatever x target the screen step produced.
    always_comb begin
        w_tw         = $signed(18'(r_total_width));
        w_left_edge  = (w_px <= 18'sd0);
        w_right_edge = (w_px >= (w_tw - 18'sd1));
        w_tx_base    = (r_state == S_DIV) ? w_tx_warp : 17'(r_px);
        w_tx_fin     = w_tx_base;
        w_moved_fin  = (r_state == S_DIV);
        if (w_left_edge) begin
            w_tx_fin    = 17'(w_tw - 18'sd2);
            w_moved_fin = 1'b1;
        end else if (w_right_edge) begin
            w_tx_fin    = 17'sd1;
            w_moved_fin = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_count <= SCNT_W'(1);
            r_total_width  <= DIM_W'(1920);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_addr)
                CFG_SCREEN_COUNT: r_screen_count <= i_cfg_data[SCNT_W-1:0];
                CFG_TOTAL_WIDTH:  r_total_width  <= i_cfg_data[DIM_W-1:0];
                default:          r_screen_count <= r_screen_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_cmd == CMD_SAMPLE)) begin
                        r_state <= (w_n_sat == '0) ? S_OUT : S_READ;
                    end
                end
                S_READ:   r_state <= S_CHECK;
                S_CHECK: begin
                    if (w_hit) begin
                        if (w_top || w_bot) begin
                            r_state <= S_NREAD;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else if (w_idx_inc == r_n) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_NREAD:  r_state <= S_NLOAD;
                S_NLOAD:  r_state <= S_DSTART;
                S_DSTART: r_state <= S_DIV;
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A new result may replace the one being taken in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out_valid && i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Datapath registers; the result is assembled in r_tx/r_ty before the output stage.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_px    <= i_pointer_x;
                    r_py    <= i_pointer_y;
                    r_idx   <= '0;
                    r_n     <= w_n_sat;
                    r_found <= 1'b0;
                    r_moved <= 1'b0;
                    r_tx    <= 17'(i_pointer_x);
                    r_ty    <= 17'(i_pointer_y);
                end
            end
            S_CHECK: begin
                if (w_hit) begin
                    r_found <= 1'b1;
                    r_off   <= DIM_W'(w_px - w_ox);
                    r_div_w <= s_rd.width;
                    r_top   <= w_top;
                    r_idx   <= (w_idx_inc == r_n) ? '0 : IDX_W'(w_idx_inc);
                    if (!(w_top || w_bot)) begin
                        r_tx    <= w_tx_fin;
                        r_moved <= w_moved_fin;
                    end
                end else begin
                    r_idx <= IDX_W'(w_idx_inc);
                end
            end
            S_NLOAD: begin
                r_nxt  <= s_rd;
                r_prod <= PROD_W'(r_off) * PROD_W'(s_rd.width);
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    r_tx    <= w_tx_fin;
                    r_ty    <= w_ty_warp;
                    r_moved <= w_moved_fin;
                end
            end
            default: r_tx <= r_tx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_found  <= r_found;
            o_moved  <= r_moved;
            o_warp_x <= r_tx;
            o_warp_y <= r_ty;
        end
    end

    assign o_out_valid = r_ovalid;

    `PSW_ASSERT_IMP(a_div_done_in_div, div_rsp.done, r_state == S_DIV)
    `PSW_ASSERT_IMP(a_out_from_seq, $rose(o_out_valid), $past(r_state) == S_OUT)
    `PSW_ASSERT_NXT(a_load_no_result, w_in_acc && (i_cmd == CMD_LOAD), r_state == S_IDLE)
    `PSW_ASSERT_IMP(a_idx_in_range, r_state == S_CHECK, CNT_W'(r_idx) < r_n)

endmodule
`default_nettype wire

// ===== rtl/psw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module psw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/psw_div.sv =====
// Restoring divider, one quotient bit per cycle, for the horizontal scaling.
// Depends on psw_pkg. The quotient must fit in DIM_W bits.
`default_nettype none
module psw_div
    import psw_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIM_W-1:0]     r_rem;
    logic [DIM_W-1:0]     r_quo;
    logic [DIM_W-1:0]     r_div;

    logic [DIM_W:0]       w_trial;
    logic                 w_fit;
    logic [DIM_W-1:0]     n_rem;

    // The upper dividend half is below the divisor, so the remainder always fits DIM_W bits.
    always_comb begin
        w_trial = {r_rem, r_quo[DIM_W-1]};
        w_fit   = (w_trial >= {1'b0, r_div});
        n_rem   = w_fit ? DIM_W'(w_trial - {1'b0, r_div}) : DIM_W'(w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
            r_rem <= i_req.dividend[PROD_W-1:DIM_W];
            r_quo <= i_req.dividend[DIM_W-1:0];
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            r_rem <= n_rem;
            r_quo <= {r_quo[DIM_W-2:0], w_fit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for pointer_screen_wrap_core: screen-table loads and pointer samples,
// checked against a behavioral predictor kept here. Depends on psw_pkg and the core RTL.
module tb_top;
    import psw_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 64;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 110;

    typedef struct {
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic [DIM_W-1:0]          w;
        logic [DIM_W-1:0]          h;
    } t_shadow;

    typedef struct {
        logic                      cmd;
        logic [2:0]                idx;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic [DIM_W-1:0]          w;
        logic [DIM_W-1:0]          h;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } t_item;

    typedef struct {
        logic             found;
        logic             moved;
        logic [TGT_W-1:0] tx;
        logic [TGT_W-1:0] ty;
    } t_warp;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_ADDR_W-1:0]     i_cfg_addr;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic                      i_cmd;
    logic [2:0]                i_screen_index;
    logic signed [COORD_W-1:0] i_origin_x;
    logic signed [COORD_W-1:0] i_origin_y;
    logic [DIM_W-1:0]          i_screen_width;
    logic [DIM_W-1:0]          i_screen_height;
    logic signed [COORD_W-1:0] i_pointer_x;
    logic signed [COORD_W-1:0] i_pointer_y;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic                      o_found;
    logic                      o_moved;
    logic signed [TGT_W-1:0]   o_warp_x;
    logic signed [TGT_W-1:0]   o_warp_y;

    // Predictor copy of the table and the two registers.
    t_shadow            screens [MAX_SCREENS];
    logic [SCNT_W-1:0]  scr_count;
    logic [DIM_W-1:0]   desk_width;
    t_warp              pending_warps [$];
    t_warp              head_warp;

    bit no_idle    = 1'b0;
    int ready_wait = 0;
    int cycles     = 0;
    int errors     = 0;
    int n_loads    = 0;
    int n_samples  = 0;
    int n_checked  = 0;
    int n_warps    = 0;
    int n_cfg      = 0;

    pointer_screen_wrap_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_screen_index  (i_screen_index),
        .i_origin_x      (i_origin_x),
        .i_origin_y      (i_origin_y),
        .i_screen_width  (i_screen_width),
        .i_screen_height (i_screen_height),
        .i_pointer_x     (i_pointer_x),
        .i_pointer_y     (i_pointer_y),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_found         (o_found),
        .o_moved         (o_moved),
        .o_warp_x        (o_warp_x),
        .o_warp_y        (o_warp_y)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, pending_warps.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic t_warp predict_warp(logic signed [COORD_W-1:0] px,
                                           logic signed [COORD_W-1:0] py);
        t_warp  r;
        int     n, i, nx;
        longint x, y, sx, sy, sw, sh, ox2, oy2, w2, h2, tx, ty, tw;
        bit     hit, top, bot;
        x = longint'(px);
        y = longint'(py);
        tx = x;
        ty = y;
        hit = 1'b0;
        r.moved = 1'b0;
        n = (scr_count > MAX_SCREENS) ? MAX_SCREENS : int'(scr_count);
        for (i = 0; i < n && !hit; i++) begin
            sx = longint'(screens[i].ox);
            sy = longint'(screens[i].oy);
            sw = longint'(screens[i].w);
            sh = longint'(screens[i].h);
            if (x >= sx && x < sx + sw && y >= sy && y < sy + sh) begin
                hit = 1'b1;
                nx = (i + 1) % n;
                ox2 = longint'(screens[nx].ox);
                oy2 = longint'(screens[nx].oy);
                w2 = longint'(screens[nx].w);
                h2 = longint'(screens[nx].h);
                // A one-row screen is both top and bottom; the top rule takes it.
                top = (y <= sy);
                bot = (y >= sy + sh - 1);
                if (top || bot) begin
                    tx = ox2 + ((x - sx) * w2) / sw;
                    ty = top ? (oy2 + h2 - 2) : (oy2 + 1);
                    r.moved = 1'b1;
                end
                tw = longint'(desk_width);
                if (x <= 0) begin
                    tx = tw - 2;
                    r.moved = 1'b1;
                end else if (x >= tw - 1) begin
                    tx = 1;
                    r.moved = 1'b1;
                end
            end
        end
        r.found = hit;
        r.tx = tx[TGT_W-1:0];
        r.ty = ty[TGT_W-1:0];
        return r;
    endfunction

    // Drives one item after a random gap and waits for its transaction.
    // Valid is left high so that a following item can go out back to back.
    task automatic issue_item(input t_item it);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= it.cmd;
        i_screen_index  <= it.idx;
        i_origin_x      <= it.ox;
        i_origin_y      <= it.oy;
        i_screen_width  <= it.w;
        i_screen_height <= it.h;
        i_pointer_x     <= it.px;
        i_pointer_y     <= it.py;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (it.cmd == CMD_LOAD) begin
            screens[it.idx] = '{it.ox, it.oy, it.w, it.h};
            n_loads++;
        end else begin
            pending_warps.push_back(predict_warp(it.px, it.py));
            n_samples++;
        end
    endtask

    // Lets every outstanding result drain, then idles for a further drain period.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_warps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (addr == CFG_SCREEN_COUNT)
            scr_count = data[SCNT_W-1:0];
        else
            desk_width = data[DIM_W-1:0];
        n_cfg++;
    endtask

    // Kind 0 is a realistic monitor, kind 1 is fully random, kind 2 is a tiny
    // screen near the origin so that one-row and zero-size cases come up.
    function automatic t_item make_load(int kind);
        t_item it;
        it.cmd = CMD_LOAD;
        it.idx = 3'($urandom);
        it.px  = 16'($urandom);
        it.py  = 16'($urandom);
        case (kind)
            0: begin
                it.ox = 16'($urandom_range(0, 30000));
                it.oy = 16'($urandom_range(0, 200) - 100);
                it.w  = 15'($urandom_range(1, 4000));
                it.h  = 15'($urandom_range(1, 3000));
            end
            1: begin
                it.ox = 16'($urandom);
                it.oy = 16'($urandom);
                it.w  = 15'($urandom);
                it.h  = 15'($urandom);
                case ($urandom_range(0, 7))
                    0: it.w = '0;
                    1: it.h = '0;
                    2: it.h = 15'(1);
                    3: it.w = 15'(1);
                    default: ;
                endcase
            end
            default: begin
                it.ox = 16'($urandom_range(0, 40) - 20);
                it.oy = 16'($urandom_range(0, 40) - 20);
                it.w  = 15'($urandom_range(0, 3));
                it.h  = 15'($urandom_range(0, 3));
            end
        endcase
        return it;
    endfunction

    // Aims a sample at a screen in use, mostly on its top or bottom row.
    function automatic t_item aim_pointer(t_item it);
        int     n, j, mode, ymode;
        longint lo, hi, top, bot, w, h;
        it.cmd = CMD_SAMPLE;
        n = (scr_count > MAX_SCREENS) ? MAX_SCREENS : int'(scr_count);
        j = int'($urandom_range(0, (n > 0) ? n - 1 : MAX_SCREENS - 1));
        mode = int'($urandom_range(0, 11));
        w = longint'(screens[j].w);
        h = longint'(screens[j].h);
        if (mode < 2 || w == 0 || h == 0) begin
            it.px = 16'($urandom);
            it.py = 16'($urandom);
        end else begin
            lo = longint'(screens[j].ox);
            hi = lo + w - 1;
            if (hi > 32767) hi = 32767;
            top = longint'(screens[j].oy);
            bot = top + h - 1;
            if (bot > 32767) bot = 32767;
            if (mode < 4)
                it.px = 16'(lo);
            else if (mode < 6)
                it.px = 16'(hi);
            else if (mode == 11)
                it.px = 16'(($urandom_range(0, 1) != 0) ? 0 : longint'(desk_width) - 1);
            else
                it.px = 16'(lo + longint'($urandom_range(0, 32'(hi - lo))));
            ymode = int'($urandom_range(0, 2));
            if (ymode == 0)
                it.py = 16'(top);
            else if (ymode == 1)
                it.py = 16'(bot);
            else
                it.py = 16'(top + longint'($urandom_range(0, 32'(bot - top))));
        end
        return it;
    endfunction

    function automatic t_item load_item(int idx, int ox, int oy, int w, int h);
        t_item it;
        it = make_load(1);
        it.idx = 3'(idx);
        it.ox  = 16'(ox);
        it.oy  = 16'(oy);
        it.w   = 15'(w);
        it.h   = 15'(h);
        return it;
    endfunction

    function automatic t_item sample_item(int px, int py);
        t_item it;
        it = make_load(1);
        it.cmd = CMD_SAMPLE;
        it.px  = 16'(px);
        it.py  = 16'(py);
        return it;
    endfunction

    task automatic test_default_config();
        // Reset values: one screen in use, so a warp lands back on screen 0.
        issue_item(load_item(0, 0, 0, 1920, 1080));
        issue_item(load_item(1, 1920, -200, 1280, 1024));
        issue_item(load_item(2, -32768, -32768, 32767, 1));
        issue_item(load_item(3, -20000, 5000, 0, 50));
        issue_item(load_item(4, -20000, 6000, 50, 0));
        issue_item(load_item(5, 32767, 32767, 1, 1));
        issue_item(load_item(6, -5, -5, 10, 10));
        issue_item(load_item(7, -30000, 20000, 32767, 100));
        issue_item(sample_item(960, 0));
        issue_item(sample_item(960, 1079));
        issue_item(sample_item(500, 500));
        issue_item(sample_item(0, 500));
        issue_item(sample_item(1919, 500));
        issue_item(sample_item(3000, 500));
    endtask

    task automatic test_table_extremes();
        cfg_write(CFG_SCREEN_COUNT, CFG_DATA_W'(8));
        cfg_write(CFG_TOTAL_WIDTH, CFG_DATA_W'(32767));
        issue_item(sample_item(2000, -200));
        issue_item(sample_item(2000, 823));
        issue_item(sample_item(-32768, -32768));
        issue_item(sample_item(-20000, 5010));
        issue_item(sample_item(-19990, 6000));
        issue_item(sample_item(32767, 32767));
        issue_item(sample_item(-29000, 20099));
        issue_item(sample_item(100, 20000));
    endtask

    task automatic test_count_limits();
        cfg_write(CFG_SCREEN_COUNT, CFG_DATA_W'(0));
        issue_item(sample_item(960, 0));
        // All data bits set: the count keeps its low four bits and saturates.
        cfg_write(CFG_SCREEN_COUNT, '1);
        issue_item(sample_item(100, 20099));
        cfg_write(CFG_TOTAL_WIDTH, CFG_DATA_W'(1));
        issue_item(sample_item(500, 500));
        cfg_write(CFG_TOTAL_WIDTH, CFG_DATA_W'(0));
        issue_item(sample_item(0, 0));
    endtask

    task automatic test_random_phases();
        t_item it;
        int    ph, kind, span, cnt, tw, k, i;
        logic [CFG_DATA_W-1:0] data;
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            no_idle = (ph % 4 == 3);
            kind = ph % 3;
            span = 0;
            for (i = 0; i < MAX_SCREENS; i++) begin
                it = make_load(kind);
                it.idx = 3'(i);
                if (kind == 0) begin
                    it.ox = 16'(span);
                    span += int'(it.w);
                end
                issue_item(it);
            end
            case (ph)
                0: cnt = 8;
                1: cnt = 1;
                2: cnt = 0;
                3: cnt = 15;
                4: cnt = 9;
                default: cnt = ($urandom_range(0, 4) == 0) ? int'($urandom_range(9, 15))
                                                           : int'($urandom_range(1, 8));
            endcase
            case (ph)
                5: tw = 32767;
                6: tw = 1;
                7: tw = 0;
                8: tw = 1920;
                default: tw = (kind == 0) ? span : int'($urandom_range(1, 32767));
            endcase
            data = CFG_DATA_W'(($urandom << SCNT_W) | cnt);
            cfg_write(CFG_SCREEN_COUNT, data);
            cfg_write(CFG_TOTAL_WIDTH, CFG_DATA_W'(tw));
            for (k = 0; k < PHASE_ITEMS; k++) begin
                it = make_load(kind);
                if ($urandom_range(0, 9) != 0) it = aim_pointer(it);
                issue_item(it);
            end
        end
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            ready_wait = 0;
        end else if (i_out_ready && o_out_valid) begin
            ready_wait = draw_wait();
            if (ready_wait > 0) i_out_ready <= 1'b0;
        end else if (!i_out_ready) begin
            if (ready_wait <= 1) i_out_ready <= 1'b1;
            ready_wait = ready_wait - 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_warps.size() == 0) begin
                $error("Result transaction with no sample outstanding");
                errors++;
            end else begin
                head_warp = pending_warps.pop_front();
                n_checked++;
                if (head_warp.moved) n_warps++;
                if (o_found !== head_warp.found) begin
                    $error("found mismatch: expected %0d actual %0d", head_warp.found, o_found);
                    errors++;
                end
                if (o_moved !== head_warp.moved) begin
                    $error("moved mismatch: expected %0d actual %0d", head_warp.moved, o_moved);
                    errors++;
                end
                if (o_warp_x !== head_warp.tx) begin
                    $error("warp_x mismatch: expected %0d actual %0d",
                           $signed(head_warp.tx), o_warp_x);
                    errors++;
                end
                if (o_warp_y !== head_warp.ty) begin
                    $error("warp_y mismatch: expected %0d actual %0d",
                           $signed(head_warp.ty), o_warp_y);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_addr      <= '0;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_cmd           <= CMD_LOAD;
        i_screen_index  <= '0;
        i_origin_x      <= '0;
        i_origin_y      <= '0;
        i_screen_width  <= '0;
        i_screen_height <= '0;
        i_pointer_x     <= '0;
        i_pointer_y     <= '0;
        scr_count  = SCNT_W'(1);
        desk_width = DIM_W'(1920);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_config();
        test_table_extremes();
        test_count_limits();
        test_random_phases();
        settle();
        if (pending_warps.size() != 0) begin
            $error("%0d expected results never arrived", pending_warps.size());
            errors++;
        end
        $display("Run covered %0d table loads and %0d pointer samples over %0d register writes.",
                 n_loads, n_samples, n_cfg);
        $display("%0d results checked, %0d of them warps; %0d mismatches.",
                 n_checked, n_warps, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== pointer_screen_wrap_core.f =====
+incdir+rtl
rtl/psw_pkg.sv
rtl/psw_ram.sv
rtl/psw_div.sv
rtl/pointer_screen_wrap_core.sv
tb/sv/tb_top.sv
